// ===== rtl/d8fd_pkg.sv =====
// Shared types and constants for the D8 flow direction cell.
`default_nettype none
package d8fd_pkg;

	localparam int NUM_NBR = 8;

	// Direction codes
	localparam logic [3:0] DIR_EDGE = 4'd0;
	localparam logic [3:0] DIR_E    = 4'd1;
	localparam logic [3:0] DIR_S    = 4'd3;
	localparam logic [3:0] DIR_W    = 4'd5;
	localparam logic [3:0] DIR_N    = 4'd7;
	localparam logic [3:0] DIR_FLAT = 4'd9;

	// Lane indexes (position minus one)
	localparam int IDX_E  = 0;
	localparam int IDX_SE = 1;
	localparam int IDX_S  = 2;
	localparam int IDX_SW = 3;
	localparam int IDX_W  = 4;
	localparam int IDX_NW = 5;
	localparam int IDX_N  = 6;
	localparam int IDX_NE = 7;

	// Per-transaction control that travels alongside the lane data
	typedef struct packed {
		logic                  vld;
		logic                  on_edge;
		logic [NUM_NBR-1:0]    nvalid;
		logic                  method;
	} ctl_t;

endpackage
`default_nettype wire

// ===== rtl/d8fd_lane.sv =====
// One neighbor lane: height difference, then fixed-point scaling.
`default_nettype none
module d8fd_lane import d8fd_pkg::*; #(
	parameter int HEIGHT_BITS = 24,
	parameter int FRAC_BITS   = 16,
	parameter bit DIAG        = 1'b0
) (
	input  wire logic                                 clk,
	input  wire logic signed [HEIGHT_BITS-1:0]        center_height,
	input  wire logic signed [HEIGHT_BITS-1:0]        height,
	input  wire logic                                 method_s1,
	output logic signed [HEIGHT_BITS+FRAC_BITS+1:0]   drop_s2
);
	localparam int DW = HEIGHT_BITS + 1;
	localparam int PW = HEIGHT_BITS + FRAC_BITS + 2;
	// round(2^FRAC_BITS / 1.41), halves up
	localparam longint unsigned KL = ((64'd1 << FRAC_BITS) * 64'd200 + 64'd141) / 64'd282;
	localparam logic [FRAC_BITS:0] KU = KL[FRAC_BITS:0];

	logic signed [DW-1:0]        diff_s1;
	logic signed [FRAC_BITS:0]   k_c;
	logic signed [PW-1:0]        prod_c;
	logic signed [PW-1:0]        shift_c;

	always_ff @(posedge clk) begin
		diff_s1 <= DW'(center_height) - DW'(height);
	end

	assign k_c     = $signed(KU);
	assign prod_c  = PW'(diff_s1) * PW'(k_c);
	assign shift_c = PW'($signed({diff_s1, {FRAC_BITS{1'b0}}}));

	always_ff @(posedge clk) begin
		if (DIAG && !method_s1) begin
			drop_s2 <= prod_c;
		end else begin
			drop_s2 <= shift_c;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/d8fd_merge.sv =====
// Merge stage: pairwise compares of the lane drops, then winner and tie rules.
`default_nettype none
module d8fd_merge import d8fd_pkg::*; #(
	parameter int DROP_BITS = 42
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [NUM_NBR-1:0][DROP_BITS-1:0] drops_s2,
	input  wire ctl_t                              ctl_s2,
	output logic                                   done,
	output logic [3:0]                             direction
);
	logic [NUM_NBR-1:0][NUM_NBR-1:0] ge_s3;
	logic [NUM_NBR-1:0]              pos_s3;
	ctl_t                            ctl_s3;

	logic [NUM_NBR-1:0] tied_c;
	logic [2:0]         first_c;
	logic               win_pos_c;
	logic [3:0]         dir_c;

	// Stage 3: every ordered pair compared in parallel
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_NBR; i++) begin
			pos_s3[i] <= $signed(drops_s2[i]) > $signed({DROP_BITS{1'b0}});
			for (int j = 0; j < NUM_NBR; j++) begin
				ge_s3[i][j] <= $signed(drops_s2[i]) >= $signed(drops_s2[j]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
		end
	end

	// Stage 4: a lane is a winner if valid and not beaten by any valid lane
	always_comb begin
		for (int i = 0; i < NUM_NBR; i++) begin
			tied_c[i] = ctl_s3.nvalid[i] & (&(~ctl_s3.nvalid | ge_s3[i]));
		end
		first_c = '0;
		for (int i = NUM_NBR - 1; i >= 0; i--) begin
			if (tied_c[i]) begin
				first_c = 3'(i);
			end
		end
		win_pos_c = |(tied_c & pos_s3);

		if (ctl_s3.on_edge) begin
			dir_c = DIR_EDGE;
		end else if (!win_pos_c) begin
			dir_c = DIR_FLAT;
		end else if (tied_c[IDX_E] && tied_c[IDX_SE] && tied_c[IDX_NE]) begin
			dir_c = DIR_E;
		end else if (tied_c[IDX_SE] && tied_c[IDX_S] && tied_c[IDX_SW]) begin
			dir_c = DIR_S;
		end else if (tied_c[IDX_SW] && tied_c[IDX_W] && tied_c[IDX_NW]) begin
			dir_c = DIR_W;
		end else if (tied_c[IDX_NW] && tied_c[IDX_N] && tied_c[IDX_NE]) begin
			dir_c = DIR_N;
		end else begin
			dir_c = {1'b0, first_c} + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_s3.vld;
		end
	end

	always_ff @(posedge clk) begin
		direction <= dir_c;
	end

endmodule
`default_nettype wire

// ===== rtl/d8_flow_direction_cell.sv =====
// Top level of the D8 flow direction cell: eight lanes and a merge stage.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------------------
//  window   | center_height, height_e..height_ne,     | start & !busy
//           | neighbour_valid, on_edge                |
//  result   | direction                               | done (one cycle, no stall)
//  config   | cfg_wdata (method)                      | cfg_we
//
// One window transaction is accepted every clock; busy is always low.
// The accepting edge loads the differences (s1), then scaling multiply (s2),
// pairwise compare (s3), and winner resolve into the output register with done.
// The multiply in each diagonal lane is the longest step of the pipe.
// Reset clears the method register (steepest slope) and the pipeline valid bits.
// The receiver cannot stall; every result is on the ports for exactly one cycle.
`default_nettype none
module d8_flow_direction_cell import d8fd_pkg::*; #(
	parameter int HEIGHT_BITS = 24,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [HEIGHT_BITS-1:0] center_height,
	input  wire logic signed [HEIGHT_BITS-1:0] height_e,
	input  wire logic signed [HEIGHT_BITS-1:0] height_se,
	input  wire logic signed [HEIGHT_BITS-1:0] height_s,
	input  wire logic signed [HEIGHT_BITS-1:0] height_sw,
	input  wire logic signed [HEIGHT_BITS-1:0] height_w,
	input  wire logic signed [HEIGHT_BITS-1:0] height_nw,
	input  wire logic signed [HEIGHT_BITS-1:0] height_n,
	input  wire logic signed [HEIGHT_BITS-1:0] height_ne,
	input  wire logic [NUM_NBR-1:0]            neighbour_valid,
	input  wire logic                          on_edge,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_wdata,
	output logic                               done,
	output logic [3:0]                         direction
);
	localparam int DROP_BITS = HEIGHT_BITS + FRAC_BITS + 2;

	logic                              method_q;
	ctl_t                              ctl_c;
	ctl_t                              ctl_s1;
	ctl_t                              ctl_s2;
	logic [NUM_NBR-1:0][HEIGHT_BITS-1:0] nbr_c;
	logic [NUM_NBR-1:0][DROP_BITS-1:0]   drops_s2;

	// fully pipelined, never refuses a window
	assign busy = 1'b0;

	// method: 0 steepest slope (diagonals scaled by 1/1.41), 1 plain difference
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= 1'b0;
		end else if (cfg_we) begin
			method_q <= cfg_wdata;
		end
	end

	assign nbr_c[IDX_E]  = height_e;
	assign nbr_c[IDX_SE] = height_se;
	assign nbr_c[IDX_S]  = height_s;
	assign nbr_c[IDX_SW] = height_sw;
	assign nbr_c[IDX_W]  = height_w;
	assign nbr_c[IDX_NW] = height_nw;
	assign nbr_c[IDX_N]  = height_n;
	assign nbr_c[IDX_NE] = height_ne;

	always_comb begin
		ctl_c.vld     = start & ~busy;
		ctl_c.on_edge = on_edge;
		ctl_c.nvalid  = neighbour_valid;
		ctl_c.method  = method_q;
	end

	// control rides alongside the lane pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl_c;
			ctl_s2 <= ctl_s1;
		end
	end

	// odd lane indexes are the diagonals (SE, SW, NW, NE)
	for (genvar g = 0; g < NUM_NBR; g++) begin : g_lane
		d8fd_lane #(
			.HEIGHT_BITS (HEIGHT_BITS),
			.FRAC_BITS   (FRAC_BITS),
			.DIAG        ((g % 2) == 1)
		) u_lane (
			.clk           (clk),
			.center_height (center_height),
			.height        ($signed(nbr_c[g])),
			.method_s1     (ctl_s1.method),
			.drop_s2       (drops_s2[g])
		);
	end

	d8fd_merge #(
		.DROP_BITS (DROP_BITS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.drops_s2  (drops_s2),
		.ctl_s2    (ctl_s2),
		.done      (done),
		.direction (direction)
	);

endmodule
`default_nettype wire
